// File: hw/rtl/ps2hid_pkg.sv
// ps2hid_pkg: widths, register indexes, scroll phase codes, sequencer states
// and helper functions for the PS/2 packet to HID mouse report block
// no dependencies
package ps2hid_pkg;

	localparam int BtnW     = 3;
	localparam int DataW    = 8;
	localparam int MagW     = 7;
	localparam int TimeW    = 16;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;
	localparam int CntW     = $clog2(MagW);

	localparam logic signed [DataW-1:0] SatPos = 8'sd127;
	localparam logic signed [DataW-1:0] SatNeg = -8'sd127;

	localparam logic [CfgIdxW-1:0] RegScrollMask = 2'd0;
	localparam logic [CfgIdxW-1:0] RegDivVert    = 2'd1;
	localparam logic [CfgIdxW-1:0] RegDivHoriz   = 2'd2;
	localparam logic [CfgIdxW-1:0] RegClickWin   = 2'd3;

	localparam logic [1:0] PhaseNone = 2'd0;
	localparam logic [1:0] PhaseHeld = 2'd1;
	localparam logic [1:0] PhaseSent = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV_V = 4'b0010,
		ST_DIV_H = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic            start;
		logic [MagW-1:0] dividend;
		logic [MagW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [MagW-1:0] quotient;
	} div_rsp_t;

	// clamp a raw movement byte using its sign and overflow bits
	function automatic logic signed [DataW-1:0] saturate(
		input logic signed [DataW-1:0] raw,
		input logic                    neg,
		input logic                    ovf
	);
		logic signed [DataW-1:0] res;
		if (neg) begin
			res = (!ovf && raw[DataW-1] && (raw != {1'b1, {(DataW-1){1'b0}}})) ? raw : SatNeg;
		end else begin
			res = (!ovf && !raw[DataW-1]) ? raw : SatPos;
		end
		return res;
	endfunction

	// magnitude of a value known to lie in -127..127
	function automatic logic [MagW-1:0] magnitude(input logic signed [DataW-1:0] val);
		logic [DataW-1:0] abs_v;
		abs_v = val[DataW-1] ? DataW'(-val) : DataW'(val);
		return abs_v[MagW-1:0];
	endfunction

endpackage

// File: hw/rtl/ps2hid_if.sv
// ps2hid_if: valid/ready channel interfaces for packet words and report words
// depends on ps2hid_pkg
interface ps2hid_pkt_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   ack_ok;
	logic [7:0]                             status_byte;
	logic signed [ps2hid_pkg::DataW-1:0]    x_movement;
	logic signed [ps2hid_pkg::DataW-1:0]    y_movement;
	logic [ps2hid_pkg::TimeW-1:0]           now_ms;

	modport source (output valid, ack_ok, status_byte, x_movement, y_movement, now_ms,
		input ready);
	modport sink (input valid, ack_ok, status_byte, x_movement, y_movement, now_ms,
		output ready);
endinterface

interface ps2hid_rpt_if;
	logic                                   valid;
	logic                                   ready;
	logic [ps2hid_pkg::BtnW-1:0]            buttons_out;
	logic signed [ps2hid_pkg::DataW-1:0]    x_out;
	logic signed [ps2hid_pkg::DataW-1:0]    y_out;
	logic signed [ps2hid_pkg::DataW-1:0]    wheel_vertical;
	logic signed [ps2hid_pkg::DataW-1:0]    wheel_horizontal;
	logic                                   last;

	modport source (output valid, buttons_out, x_out, y_out, wheel_vertical,
		wheel_horizontal, last, input ready);
	modport sink (input valid, buttons_out, x_out, y_out, wheel_vertical,
		wheel_horizontal, last, output ready);
endinterface

// File: hw/rtl/ps2hid_div.sv
// ps2hid_div: shared restoring divider, unsigned 7-bit magnitudes, one
// quotient bit per cycle; depends on ps2hid_pkg
module ps2hid_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ps2hid_pkg::div_req_t req,
	output ps2hid_pkg::div_rsp_t rsp
);

	logic                              busy_q;
	logic [ps2hid_pkg::CntW-1:0]       cnt_q;
	logic [ps2hid_pkg::MagW-1:0]       num_q;
	logic [ps2hid_pkg::MagW-1:0]       rem_q;
	logic [ps2hid_pkg::MagW-1:0]       den_q;
	logic [ps2hid_pkg::MagW:0]         trial;
	logic                              fits;
	logic [ps2hid_pkg::MagW:0]         diff;
	logic                              last_step;

	assign trial     = {rem_q, num_q[ps2hid_pkg::MagW-1]};
	assign fits      = trial >= {1'b0, den_q};
	assign diff      = trial - {1'b0, den_q};
	assign last_step = busy_q && (cnt_q == ps2hid_pkg::CntW'(ps2hid_pkg::MagW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !last_step;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	// quotient bits shift into num_q as the dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			num_q <= {num_q[ps2hid_pkg::MagW-2:0], fits};
			rem_q <= fits ? diff[ps2hid_pkg::MagW-1:0] : trial[ps2hid_pkg::MagW-1:0];
		end
	end

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last_step && !req.start;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

// File: hw/rtl/ps2_to_hid_mouse_report.sv
// ps2_to_hid_mouse_report: top level, packet decode, scroll/click state,
// sequencer and report register; depends on ps2hid_pkg, ps2hid_if, ps2hid_div
//
// channel   dir  word
// pkt       in   ack_ok, status_byte, x_movement, y_movement, now_ms
// rpt       out  buttons_out, x_out, y_out, wheel_vertical, wheel_horizontal, last
// cfg_*     in   write enable, register index, data (no read-back)
//
// a packet is decoded in its accept cycle; a plain report moves from the work
// registers to the output register once that is free, and a click pair loads its
// click word, then its closing word; in scroll mode each axis runs on the shared
// divider (start, seven quotient bits, done), vertical axis first, then horizontal
// pkt.ready is high only while the sequencer is idle; a report waiting on
// rpt.ready holds the sequencer in its emit state, not the prior packet
// reset clears the scroll state and previous buttons and resets the config registers at once
module ps2_to_hid_mouse_report (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ps2hid_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [ps2hid_pkg::CfgDataW-1:0]       cfg_data,
	ps2hid_pkt_if.sink                            pkt,
	ps2hid_rpt_if.source                          rpt
);

	// configuration registers
	logic [ps2hid_pkg::BtnW-1:0]  mask_q;
	logic [ps2hid_pkg::MagW-1:0]  div_v_q;
	logic [ps2hid_pkg::MagW-1:0]  div_h_q;
	logic [ps2hid_pkg::TimeW-1:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			div_v_q <= ps2hid_pkg::MagW'(1);
			div_h_q <= ps2hid_pkg::MagW'(1);
			win_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ps2hid_pkg::RegScrollMask: mask_q  <= cfg_data[ps2hid_pkg::BtnW-1:0];
				ps2hid_pkg::RegDivVert:    div_v_q <= cfg_data[ps2hid_pkg::MagW-1:0];
				ps2hid_pkg::RegDivHoriz:   div_h_q <= cfg_data[ps2hid_pkg::MagW-1:0];
				ps2hid_pkg::RegClickWin:   win_q   <= cfg_data[ps2hid_pkg::TimeW-1:0];
				default: ;
			endcase
		end
	end

	ps2hid_pkg::state_t state_q;
	logic [ps2hid_pkg::BtnW-1:0]  prev_btn_q;
	logic [1:0]                   phase_q;
	logic [ps2hid_pkg::TimeW-1:0] press_q;

	// decode of the incoming word
	logic                          accept;
	logic                          active;
	logic [ps2hid_pkg::BtnW-1:0]   btn;
	logic signed [ps2hid_pkg::DataW-1:0] xs;
	logic signed [ps2hid_pkg::DataW-1:0] ys;
	logic                          motion;
	logic                          combo_full;
	logic                          combo_free;
	logic                          scroll;
	logic                          click;
	logic [ps2hid_pkg::TimeW-1:0]  held_ms;

	assign pkt.ready  = (state_q == ps2hid_pkg::ST_IDLE);
	assign accept     = pkt.valid && pkt.ready;
	assign btn        = pkt.status_byte[ps2hid_pkg::BtnW-1:0];
	assign active     = accept && pkt.ack_ok &&
		((pkt.x_movement != '0) || (pkt.y_movement != '0) || (btn != prev_btn_q));
	assign xs         = ps2hid_pkg::saturate(pkt.x_movement, pkt.status_byte[4],
		pkt.status_byte[6]);
	assign ys         = ps2hid_pkg::saturate(pkt.y_movement, pkt.status_byte[5],
		pkt.status_byte[7]);
	assign motion     = (xs != '0) || (ys != '0);
	assign combo_full = (mask_q != '0) && ((btn & mask_q) == mask_q);
	assign combo_free = (mask_q != '0) && ((btn & mask_q) == '0);
	assign scroll     = combo_full && motion;
	assign held_ms    = pkt.now_ms - press_q;
	assign click      = combo_free && (win_q != '0) && (phase_q == ps2hid_pkg::PhaseHeld) &&
		(held_ms < win_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_btn_q <= '0;
			phase_q    <= ps2hid_pkg::PhaseNone;
			press_q    <= '0;
		end else if (active) begin
			prev_btn_q <= btn;
			if (combo_full) begin
				if (phase_q == ps2hid_pkg::PhaseNone) begin
					press_q <= pkt.now_ms;
				end
				if (motion) begin
					phase_q <= ps2hid_pkg::PhaseSent;
				end else if (phase_q == ps2hid_pkg::PhaseNone) begin
					phase_q <= ps2hid_pkg::PhaseHeld;
				end
			end else if (combo_free) begin
				phase_q <= ps2hid_pkg::PhaseNone;
			end
		end
	end

	// per-packet work registers
	logic [ps2hid_pkg::BtnW-1:0]         btn_q;
	logic [ps2hid_pkg::BtnW-1:0]         click_btn_q;
	logic signed [ps2hid_pkg::DataW-1:0] x_q;
	logic signed [ps2hid_pkg::DataW-1:0] y_q;
	logic signed [ps2hid_pkg::DataW-1:0] v_q;
	logic signed [ps2hid_pkg::DataW-1:0] h_q;
	logic [ps2hid_pkg::MagW-1:0]         xmag_q;
	logic [ps2hid_pkg::MagW-1:0]         ymag_q;
	logic                                xneg_q;
	logic                                yneg_q;
	logic                                click_q;
	logic                                start_q;

	ps2hid_pkg::div_req_t div_req;
	ps2hid_pkg::div_rsp_t div_rsp;
	logic [ps2hid_pkg::DataW-1:0]        q_ext;
	logic signed [ps2hid_pkg::DataW-1:0] q_signed;
	logic                                q_neg;

	assign q_ext    = {1'b0, div_rsp.quotient};
	assign q_neg    = (state_q == ps2hid_pkg::ST_DIV_V) ? yneg_q : xneg_q;
	assign q_signed = q_neg ? ps2hid_pkg::DataW'(-q_ext) : q_ext;

	// out register
	logic out_valid_q;
	logic load;
	assign load = (state_q == ps2hid_pkg::ST_EMIT) && (!out_valid_q || rpt.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ps2hid_pkg::ST_IDLE;
			start_q <= 1'b0;
			click_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ps2hid_pkg::ST_IDLE: begin
					if (active) begin
						click_q <= click;
						start_q <= scroll;
						state_q <= scroll ? ps2hid_pkg::ST_DIV_V : ps2hid_pkg::ST_EMIT;
					end
				end
				ps2hid_pkg::ST_DIV_V: begin
					if (div_rsp.done) begin
						start_q <= 1'b1;
						state_q <= ps2hid_pkg::ST_DIV_H;
					end
				end
				ps2hid_pkg::ST_DIV_H: begin
					if (div_rsp.done) begin
						state_q <= ps2hid_pkg::ST_EMIT;
					end
				end
				ps2hid_pkg::ST_EMIT: begin
					if (load) begin
						if (click_q) begin
							click_q <= 1'b0;
						end else begin
							state_q <= ps2hid_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= ps2hid_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			btn_q       <= btn & ~mask_q;
			click_btn_q <= btn | mask_q;
			x_q         <= scroll ? '0 : xs;
			y_q         <= scroll ? '0 : ps2hid_pkg::DataW'(-ys);
			v_q         <= '0;
			h_q         <= '0;
			xmag_q      <= ps2hid_pkg::magnitude(xs);
			ymag_q      <= ps2hid_pkg::magnitude(ys);
			xneg_q      <= xs[ps2hid_pkg::DataW-1];
			yneg_q      <= ys[ps2hid_pkg::DataW-1];
		end else if (div_rsp.done && (state_q == ps2hid_pkg::ST_DIV_V)) begin
			v_q <= q_signed;
		end else if (div_rsp.done && (state_q == ps2hid_pkg::ST_DIV_H)) begin
			h_q <= q_signed;
		end
	end

	// a divisor written as zero acts as one
	always_comb begin
		div_req.start = start_q;
		if (state_q == ps2hid_pkg::ST_DIV_V) begin
			div_req.dividend = ymag_q;
			div_req.divisor  = (div_v_q == '0) ? ps2hid_pkg::MagW'(1) : div_v_q;
		end else begin
			div_req.dividend = xmag_q;
			div_req.divisor  = (div_h_q == '0) ? ps2hid_pkg::MagW'(1) : div_h_q;
		end
	end

	ps2hid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic [ps2hid_pkg::BtnW-1:0]         r_btn_q;
	logic signed [ps2hid_pkg::DataW-1:0] r_x_q;
	logic signed [ps2hid_pkg::DataW-1:0] r_y_q;
	logic signed [ps2hid_pkg::DataW-1:0] r_v_q;
	logic signed [ps2hid_pkg::DataW-1:0] r_h_q;
	logic                                r_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// click word: whole scroll combination pressed, no wheel
	always_ff @(posedge clk) begin
		if (load) begin
			r_btn_q  <= click_q ? click_btn_q : btn_q;
			r_x_q    <= x_q;
			r_y_q    <= y_q;
			r_v_q    <= click_q ? '0 : v_q;
			r_h_q    <= click_q ? '0 : h_q;
			r_last_q <= !click_q;
		end
	end

	assign rpt.valid            = out_valid_q;
	assign rpt.buttons_out      = r_btn_q;
	assign rpt.x_out            = r_x_q;
	assign rpt.y_out            = r_y_q;
	assign rpt.wheel_vertical   = r_v_q;
	assign rpt.wheel_horizontal = r_h_q;
	assign rpt.last             = r_last_q;

	a_div_start_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (state_q == ps2hid_pkg::ST_DIV_V) || (state_q == ps2hid_pkg::ST_DIV_H))
		else $error("divider started outside a divide state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ps2hid_pkg::ST_DIV_V) || (state_q == ps2hid_pkg::ST_DIV_H))
		else $error("divider finished outside a divide state");

	a_click_then_last: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && rpt.ready && !rpt.last |=> rpt.valid && rpt.last)
		else $error("click word not followed by its closing word");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("scroll phase reached unused code");

	a_wheel_no_xy: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && ((rpt.wheel_vertical != '0) || (rpt.wheel_horizontal != '0)) |->
		(rpt.x_out == '0) && (rpt.y_out == '0))
		else $error("scroll word carries pointer motion");

endmodule
